### rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants for the triangle circumcircle block.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int OUT_W = 48;

	localparam logic [1:0] ORI_ZERO = 2'b00;
	localparam logic [1:0] ORI_POS  = 2'b01;
	localparam logic [1:0] ORI_NEG  = 2'b11;

	typedef struct packed {
		logic       degenerate;
		logic [1:0] orientation;
	} cls_t;

endpackage

### rtl/tcc_fifo.sv
// ----------------------------------------------------------------------------
// tcc_fifo
// Small show-ahead queue; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module tcc_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not advance on push");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count did not drop on pop");
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH))
		else $error("queue count beyond depth");

endmodule

### rtl/tcc_front.sv
// ----------------------------------------------------------------------------
// tcc_front
// Takes a triangle, forms edge vectors, squared lengths and cross product,
// and classifies orientation / degeneracy.
// ----------------------------------------------------------------------------
module tcc_front #(
	parameter int C = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic signed [C-1:0]   a_x,
	input  logic signed [C-1:0]   a_y,
	input  logic signed [C-1:0]   b_x,
	input  logic signed [C-1:0]   b_y,
	input  logic signed [C-1:0]   c_x,
	input  logic signed [C-1:0]   c_y,
	output logic                  q_push,
	input  logic                  q_full,
	output logic signed [C-1:0]   ax,
	output logic signed [C-1:0]   ay,
	output logic signed [C:0]     px,
	output logic signed [C:0]     py,
	output logic signed [C:0]     qx,
	output logic signed [C:0]     qy,
	output logic [2*C+1:0]        pn,
	output logic [2*C+1:0]        qn,
	output logic signed [2*C+2:0] crs,
	output tcc_pkg::cls_t         cls
);
	import tcc_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3;
	logic signed [C-1:0]   ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3;
	logic signed [C:0]     px_s1, py_s1, qx_s1, qy_s1;
	logic signed [C:0]     px_s2, py_s2, qx_s2, qy_s2;
	logic signed [C:0]     px_s3, py_s3, qx_s3, qy_s3;
	logic signed [2*C+1:0] pxx_s2, pyy_s2, qxx_s2, qyy_s2, xq_s2, yq_s2;
	logic [2*C+2:0]        pn_w, qn_w;
	logic [2*C+1:0]        pn_s3, qn_s3;
	logic signed [2*C+2:0] crs_s3;

	assign en     = !(v_s3 && q_full);
	assign full   = !en;
	assign q_push = v_s3 && !q_full;

	assign pn_w = {1'b0, pxx_s2} + {1'b0, pyy_s2};
	assign qn_w = {1'b0, qxx_s2} + {1'b0, qyy_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= a_x;
			ay_s1  <= a_y;
			px_s1  <= {b_x[C-1], b_x} - {a_x[C-1], a_x};
			py_s1  <= {b_y[C-1], b_y} - {a_y[C-1], a_y};
			qx_s1  <= {c_x[C-1], c_x} - {a_x[C-1], a_x};
			qy_s1  <= {c_y[C-1], c_y} - {a_y[C-1], a_y};
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			qx_s2  <= qx_s1;
			qy_s2  <= qy_s1;
			pxx_s2 <= px_s1 * px_s1;
			pyy_s2 <= py_s1 * py_s1;
			qxx_s2 <= qx_s1 * qx_s1;
			qyy_s2 <= qy_s1 * qy_s1;
			xq_s2  <= px_s1 * qy_s1;
			yq_s2  <= py_s1 * qx_s1;
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			px_s3  <= px_s2;
			py_s3  <= py_s2;
			qx_s3  <= qx_s2;
			qy_s3  <= qy_s2;
			pn_s3  <= pn_w[2*C+1:0];
			qn_s3  <= qn_w[2*C+1:0];
			crs_s3 <= {xq_s2[2*C+1], xq_s2} - {yq_s2[2*C+1], yq_s2};
		end
	end

	always_comb begin
		cls.degenerate = (crs_s3 == '0);
		if (crs_s3 == '0) begin
			cls.orientation = ORI_ZERO;
		end else if (crs_s3[2*C+2]) begin
			cls.orientation = ORI_NEG;
		end else begin
			cls.orientation = ORI_POS;
		end
	end

	assign ax  = ax_s3;
	assign ay  = ay_s3;
	assign px  = px_s3;
	assign py  = py_s3;
	assign qx  = qx_s3;
	assign qy  = qy_s3;
	assign pn  = pn_s3;
	assign qn  = qn_s3;
	assign crs = crs_s3;

endmodule

### rtl/tcc_div.sv
// ----------------------------------------------------------------------------
// tcc_div
// Two-lane pipelined restoring divider, one quotient bit per stage,
// lanes share the divisor.
// ----------------------------------------------------------------------------
module tcc_div #(
	parameter int NW = 67,
	parameter int DW = 35,
	parameter int TW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [NW-1:0] num_a,
	input  logic [NW-1:0] num_b,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag_in,
	output logic          out_v,
	output logic [NW-1:0] quo_a,
	output logic [NW-1:0] quo_b,
	output logic [DW-1:0] rem_a,
	output logic [DW-1:0] rem_b,
	output logic [DW-1:0] den_out,
	output logic [TW-1:0] tag_out
);
	logic [NW-1:0] na_s [1:NW];
	logic [NW-1:0] nb_s [1:NW];
	logic [NW-1:0] qa_s [1:NW];
	logic [NW-1:0] qb_s [1:NW];
	logic [DW-1:0] ra_s [1:NW];
	logic [DW-1:0] rb_s [1:NW];
	logic [DW-1:0] d_s  [1:NW];
	logic [TW-1:0] t_s  [1:NW];
	logic          v_s  [1:NW];

	for (genvar i = 0; i < NW; i++) begin : g_st
		logic [NW-1:0] na, nb, qa, qb;
		logic [DW-1:0] ra, rb, dn;
		logic [TW-1:0] tg;
		logic          vi;
		logic [DW:0]   ta, tb;
		logic          ga, gb;

		if (i == 0) begin : g_first
			assign na = num_a;
			assign nb = num_b;
			assign qa = '0;
			assign qb = '0;
			assign ra = '0;
			assign rb = '0;
			assign dn = den;
			assign tg = tag_in;
			assign vi = in_v;
		end else begin : g_next
			assign na = na_s[i];
			assign nb = nb_s[i];
			assign qa = qa_s[i];
			assign qb = qb_s[i];
			assign ra = ra_s[i];
			assign rb = rb_s[i];
			assign dn = d_s[i];
			assign tg = t_s[i];
			assign vi = v_s[i];
		end

		assign ta = {ra, na[NW-1]};
		assign tb = {rb, nb[NW-1]};
		assign ga = (ta >= {1'b0, dn});
		assign gb = (tb >= {1'b0, dn});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				na_s[i+1] <= na << 1;
				nb_s[i+1] <= nb << 1;
				qa_s[i+1] <= (qa << 1) | NW'(ga);
				qb_s[i+1] <= (qb << 1) | NW'(gb);
				ra_s[i+1] <= ga ? DW'(ta - {1'b0, dn}) : ta[DW-1:0];
				rb_s[i+1] <= gb ? DW'(tb - {1'b0, dn}) : tb[DW-1:0];
				d_s[i+1]  <= dn;
				t_s[i+1]  <= tg;
			end
		end
	end

	assign out_v   = v_s[NW];
	assign quo_a   = qa_s[NW];
	assign quo_b   = qb_s[NW];
	assign rem_a   = ra_s[NW];
	assign rem_b   = rb_s[NW];
	assign den_out = d_s[NW];
	assign tag_out = t_s[NW];

endmodule

### rtl/tcc_sqrt.sv
// ----------------------------------------------------------------------------
// tcc_sqrt
// Pipelined integer square root with remainder, one root bit per stage.
// ----------------------------------------------------------------------------
module tcc_sqrt #(
	parameter int SW = 98,
	parameter int TW = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [SW-1:0]    rad,
	input  logic [TW-1:0]    tag_in,
	output logic             out_v,
	output logic [SW/2-1:0]  root,
	output logic [SW/2+1:0]  rem,
	output logic [TW-1:0]    tag_out
);
	localparam int RW = SW / 2;

	logic [SW-1:0]   x_s [1:RW];
	logic [RW-1:0]   r_s [1:RW];
	logic [RW+1:0]   m_s [1:RW];
	logic [TW-1:0]   t_s [1:RW];
	logic            v_s [1:RW];

	for (genvar i = 0; i < RW; i++) begin : g_st
		logic [SW-1:0] xi;
		logic [RW-1:0] ri;
		logic [RW+1:0] mi;
		logic [TW-1:0] tg;
		logic          vi;
		logic [RW+3:0] cur, trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign xi = rad;
			assign ri = '0;
			assign mi = '0;
			assign tg = tag_in;
			assign vi = in_v;
		end else begin : g_next
			assign xi = x_s[i];
			assign ri = r_s[i];
			assign mi = m_s[i];
			assign tg = t_s[i];
			assign vi = v_s[i];
		end

		assign cur   = {mi, xi[SW-1:SW-2]};
		assign trial = (RW+4)'({ri, 2'b01});
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1] <= xi << 2;
				r_s[i+1] <= (ri << 1) | RW'(ge);
				m_s[i+1] <= ge ? (RW+2)'(cur - trial) : cur[RW+1:0];
				t_s[i+1] <= tg;
			end
		end
	end

	assign out_v   = v_s[RW];
	assign root    = r_s[RW];
	assign rem     = m_s[RW];
	assign tag_out = t_s[RW];

endmodule

### rtl/tcc_back.sv
// ----------------------------------------------------------------------------
// tcc_back
// Forms the offset numerators, divides, rounds and saturates the center,
// and takes the rounded square root for the radius.
// ----------------------------------------------------------------------------
module tcc_back #(
	parameter int C = 16,
	parameter int F = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  pop,
	input  logic signed [C-1:0]   ax,
	input  logic signed [C-1:0]   ay,
	input  logic signed [C:0]     px,
	input  logic signed [C:0]     py,
	input  logic signed [C:0]     qx,
	input  logic signed [C:0]     qy,
	input  logic [2*C+1:0]        pn,
	input  logic [2*C+1:0]        qn,
	input  logic signed [2*C+2:0] crs,
	input  tcc_pkg::cls_t         cls,
	output logic                  out_push,
	input  logic                  out_full,
	output logic [47:0]           cen_x,
	output logic [47:0]           cen_y,
	output logic [47:0]           rad,
	output tcc_pkg::cls_t         cls_out
);
	import tcc_pkg::*;

	localparam int PW  = 2*C + 3;        // partial product width
	localparam int NSW = 3*C + 6;        // signed numerator sum width
	localparam int NMW = 3*C + 3;        // numerator magnitude width
	localparam int NW  = NMW + F;        // dividend / quotient width
	localparam int DW  = 2*C + 3;        // divisor width
	localparam int TW1 = 2*C + 5;
	localparam int EW  = (NW + 1 > 51) ? NW + 1 : 51;
	localparam int SW  = 98;
	localparam int RW  = SW / 2;
	localparam int TW2 = 3*OUT_W - OUT_W + 4;

	logic en;

	// stage 1: partial products, squared lengths split into halves of C+1 bits
	logic v_s1;
	logic signed [PW-1:0] ypl_s1, yph_s1, yql_s1, yqh_s1;
	logic signed [PW-1:0] xql_s1, xqh_s1, xpl_s1, xph_s1;
	logic signed [C-1:0]  ax_s1, ay_s1;
	logic signed [2*C+2:0] crs_s1;
	cls_t cls_s1;

	// stage 2: numerators and divisor
	logic v_s2;
	logic signed [NSW-1:0] nx_s2, ny_s2;
	logic [DW-1:0]         den_s2;
	logic signed [C-1:0]   ax_s2, ay_s2;
	logic                  cneg_s2;
	cls_t cls_s2;
	logic [2*C+2:0]        cabs;

	// stage 3: magnitudes and signs
	logic v_s3;
	logic [NW-1:0] numx_s3, numy_s3;
	logic [DW-1:0] den_s3;
	logic [TW1-1:0] tag_s3;
	logic signed [NSW-1:0] nxa, nya;

	// divider
	logic           dv;
	logic [NW-1:0]  dqx, dqy;
	logic [DW-1:0]  drx, dry, dden;
	logic [TW1-1:0] dtag;

	// stage 4: rounded quotients
	logic v_s4;
	logic [NW:0]    ox_s4, oy_s4;
	logic [TW1-1:0] tag_s4;

	// stage 5: center, square partial products
	logic v_s5;
	logic [47:0] cx_s5, cy_s5;
	logic        big_s5;
	cls_t        cls_s5;
	logic [47:0] llx_s5, lhx_s5, hhx_s5, lly_s5, lhy_s5, hhy_s5;
	logic [EW-1:0] ex, ey;
	logic [49:0]   sox, soy;
	logic signed [51:0] cenx_w, ceny_w;
	logic signed [C-1:0] t_ax, t_ay;
	logic t_sx, t_sy;
	cls_t t_cls;

	// stage 6, 7: sum of squares
	logic v_s6, v_s7;
	logic [95:0] sqx_s6, sqy_s6;
	logic [TW2-1:0] tag_s6, tag_s7;
	logic [SW-1:0]  s_s7;

	// sqrt
	logic           sv;
	logic [RW-1:0]  sroot;
	logic [RW+1:0]  srem;
	logic [TW2-1:0] stag;

	// stage 8: output register
	logic v_s8;
	logic [47:0] cx_s8, cy_s8, rad_s8;
	cls_t cls_s8;
	logic [RW:0] rr;
	logic [47:0] s_cx, s_cy;
	logic        s_big;
	cls_t        s_cls;

	assign en       = !(v_s8 && out_full);
	assign pop      = en && in_valid;
	assign out_push = v_s8 && !out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= dv;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= sv;
		end
	end

	assign cabs = crs_s1[2*C+2] ? -crs_s1 : crs_s1;
	assign nxa  = nx_s2[NSW-1] ? -nx_s2 : nx_s2;
	assign nya  = ny_s2[NSW-1] ? -ny_s2 : ny_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ypl_s1  <= qy * $signed({1'b0, pn[C:0]});
			yph_s1  <= qy * $signed({1'b0, pn[2*C+1:C+1]});
			yql_s1  <= py * $signed({1'b0, qn[C:0]});
			yqh_s1  <= py * $signed({1'b0, qn[2*C+1:C+1]});
			xql_s1  <= px * $signed({1'b0, qn[C:0]});
			xqh_s1  <= px * $signed({1'b0, qn[2*C+1:C+1]});
			xpl_s1  <= qx * $signed({1'b0, pn[C:0]});
			xph_s1  <= qx * $signed({1'b0, pn[2*C+1:C+1]});
			ax_s1   <= ax;
			ay_s1   <= ay;
			crs_s1  <= crs;
			cls_s1  <= cls;

			nx_s2   <= (NSW'(yph_s1) <<< (C+1)) + NSW'(ypl_s1)
				- (NSW'(yqh_s1) <<< (C+1)) - NSW'(yql_s1);
			ny_s2   <= (NSW'(xqh_s1) <<< (C+1)) + NSW'(xql_s1)
				- (NSW'(xph_s1) <<< (C+1)) - NSW'(xpl_s1);
			den_s2  <= {cabs[2*C+1:0], 1'b0};
			cneg_s2 <= crs_s1[2*C+2];
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			cls_s2  <= cls_s1;

			numx_s3 <= NW'(nxa[NMW-1:0]) << F;
			numy_s3 <= NW'(nya[NMW-1:0]) << F;
			den_s3  <= den_s2;
			tag_s3  <= {ax_s2, ay_s2, nx_s2[NSW-1] ^ cneg_s2,
				ny_s2[NSW-1] ^ cneg_s2, cls_s2};
		end
	end

	tcc_div #(.NW(NW), .DW(DW), .TW(TW1)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s3),
		.num_a   (numx_s3),
		.num_b   (numy_s3),
		.den     (den_s3),
		.tag_in  (tag_s3),
		.out_v   (dv),
		.quo_a   (dqx),
		.quo_b   (dqy),
		.rem_a   (drx),
		.rem_b   (dry),
		.den_out (dden),
		.tag_out (dtag)
	);

	// round to nearest, ties away from zero (magnitudes)
	always_ff @(posedge clk) begin
		if (en) begin
			ox_s4  <= (NW+1)'(dqx) + (NW+1)'({drx, 1'b0} >= {1'b0, dden});
			oy_s4  <= (NW+1)'(dqy) + (NW+1)'({dry, 1'b0} >= {1'b0, dden});
			tag_s4 <= dtag;
		end
	end

	assign {t_ax, t_ay, t_sx, t_sy, t_cls} = tag_s4;
	assign ex  = EW'(ox_s4);
	assign ey  = EW'(oy_s4);
	assign sox = (ex > (EW'(1) << 49)) ? (50'(1) << 49) : ex[49:0];
	assign soy = (ey > (EW'(1) << 49)) ? (50'(1) << 49) : ey[49:0];
	assign cenx_w = (t_sx ? -$signed({2'b00, sox}) : $signed({2'b00, sox}))
		+ (52'(t_ax) <<< F);
	assign ceny_w = (t_sy ? -$signed({2'b00, soy}) : $signed({2'b00, soy}))
		+ (52'(t_ay) <<< F);

	function automatic logic [47:0] sat48(input logic signed [51:0] v);
		logic [47:0] r;
		if (v[51:47] == {5{v[47]}}) begin
			r = v[47:0];
		end else if (v[51]) begin
			r = {1'b1, 47'b0};
		end else begin
			r = {1'b0, {47{1'b1}}};
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s5  <= sat48(cenx_w);
			cy_s5  <= sat48(ceny_w);
			big_s5 <= (ex >= (EW'(1) << 48)) || (ey >= (EW'(1) << 48));
			cls_s5 <= t_cls;
			llx_s5 <= ex[23:0] * ex[23:0];
			lhx_s5 <= ex[23:0] * ex[47:24];
			hhx_s5 <= ex[47:24] * ex[47:24];
			lly_s5 <= ey[23:0] * ey[23:0];
			lhy_s5 <= ey[23:0] * ey[47:24];
			hhy_s5 <= ey[47:24] * ey[47:24];

			sqx_s6 <= ({hhx_s5, 48'b0}) + (96'(lhx_s5) << 25) + 96'(llx_s5);
			sqy_s6 <= ({hhy_s5, 48'b0}) + (96'(lhy_s5) << 25) + 96'(lly_s5);
			tag_s6 <= {cx_s5, cy_s5, big_s5, cls_s5};

			s_s7   <= SW'(sqx_s6) + SW'(sqy_s6);
			tag_s7 <= tag_s6;
		end
	end

	tcc_sqrt #(.SW(SW), .TW(TW2)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s7),
		.rad     (s_s7),
		.tag_in  (tag_s7),
		.out_v   (sv),
		.root    (sroot),
		.rem     (srem),
		.tag_out (stag)
	);

	assign {s_cx, s_cy, s_big, s_cls} = stag;
	assign rr = (RW+1)'(sroot) + (RW+1)'((RW+2)'(srem) > (RW+2)'(sroot));

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s8 <= s_cls;
			if (s_cls.degenerate) begin
				cx_s8  <= '0;
				cy_s8  <= '0;
				rad_s8 <= '0;
			end else begin
				cx_s8  <= s_cx;
				cy_s8  <= s_cy;
				rad_s8 <= (s_big || rr[RW:48] != '0) ? {48{1'b1}} : rr[47:0];
			end
		end
	end

	assign cen_x   = cx_s8;
	assign cen_y   = cy_s8;
	assign rad     = rad_s8;
	assign cls_out = cls_s8;

endmodule

### rtl/triangle_circumcircle.sv
// ----------------------------------------------------------------------------
// triangle_circumcircle
// Circumcenter and circumradius of a triangle with integer vertices,
// fixed-point results with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  input     | push / full        | a_x a_y b_x b_y c_x c_y
//  result    | pop / empty        | center_x center_y radius degenerate
//            |                    | orientation
//
// One triangle per cycle sustained while results are popped; every stage is pipelined.
// The path from accept to empty low runs through the one-bit-per-stage divider
// (3*COORD_BITS+3+FRAC_BITS stages) and the 49-stage square root.
// A four-entry queue separates the front end from the back end; a stall at
// the result queue holds the back end only, and full rises once the queue
// and front stages fill. Reset clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module triangle_circumcircle #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic signed [COORD_BITS-1:0] c_x,
	input  logic signed [COORD_BITS-1:0] c_y,
	input  logic                         pop,
	output logic                         empty,
	output logic signed [47:0]           center_x,
	output logic signed [47:0]           center_y,
	output logic [47:0]                  radius,
	output logic                         degenerate,
	output logic signed [1:0]            orientation
);
	import tcc_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int MW = 12*C + 14;
	localparam int OW = 3*OUT_W + 3;

	logic                  fq_push, fq_full, fq_empty, fq_pop;
	logic signed [C-1:0]   f_ax, f_ay, b_ax, b_ay;
	logic signed [C:0]     f_px, f_py, f_qx, f_qy, b_px, b_py, b_qx, b_qy;
	logic [2*C+1:0]        f_pn, f_qn, b_pn, b_qn;
	logic signed [2*C+2:0] f_crs, b_crs;
	cls_t                  f_cls, b_cls, o_cls;
	logic [MW-1:0]         fq_wdata, fq_rdata;

	logic                  bk_push, of_full;
	logic [47:0]           bk_cx, bk_cy, bk_rad;
	cls_t                  bk_cls;
	logic [OW-1:0]         of_rdata;

	tcc_front #(.C(C)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.a_x    (a_x),
		.a_y    (a_y),
		.b_x    (b_x),
		.b_y    (b_y),
		.c_x    (c_x),
		.c_y    (c_y),
		.q_push (fq_push),
		.q_full (fq_full),
		.ax     (f_ax),
		.ay     (f_ay),
		.px     (f_px),
		.py     (f_py),
		.qx     (f_qx),
		.qy     (f_qy),
		.pn     (f_pn),
		.qn     (f_qn),
		.crs    (f_crs),
		.cls    (f_cls)
	);

	assign fq_wdata = {f_ax, f_ay, f_px, f_py, f_qx, f_qy, f_pn, f_qn, f_crs, f_cls};

	tcc_fifo #(.W(MW), .DEPTH(4)) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.wdata  (fq_wdata),
		.full   (fq_full),
		.pop    (fq_pop),
		.rdata  (fq_rdata),
		.empty  (fq_empty)
	);

	assign {b_ax, b_ay, b_px, b_py, b_qx, b_qy, b_pn, b_qn, b_crs, b_cls} = fq_rdata;

	tcc_back #(.C(C), .F(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!fq_empty),
		.pop      (fq_pop),
		.ax       (b_ax),
		.ay       (b_ay),
		.px       (b_px),
		.py       (b_py),
		.qx       (b_qx),
		.qy       (b_qy),
		.pn       (b_pn),
		.qn       (b_qn),
		.crs      (b_crs),
		.cls      (b_cls),
		.out_push (bk_push),
		.out_full (of_full),
		.cen_x    (bk_cx),
		.cen_y    (bk_cy),
		.rad      (bk_rad),
		.cls_out  (bk_cls)
	);

	tcc_fifo #(.W(OW), .DEPTH(2)) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (bk_push),
		.wdata  ({bk_cx, bk_cy, bk_rad, bk_cls}),
		.full   (of_full),
		.pop    (pop),
		.rdata  (of_rdata),
		.empty  (empty)
	);

	assign center_x    = of_rdata[OW-1 -: 48];
	assign center_y    = of_rdata[OW-49 -: 48];
	assign radius      = of_rdata[OW-97 -: 48];
	assign o_cls       = of_rdata[2:0];
	assign degenerate  = o_cls.degenerate;
	assign orientation = o_cls.orientation;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && degenerate) |-> (center_x == '0 && center_y == '0 &&
		radius == '0 && orientation == ORI_ZERO))
		else $error("degenerate item with nonzero result");
	a_orient: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !degenerate) |-> (orientation == ORI_POS || orientation == ORI_NEG))
		else $error("non-degenerate item without orientation");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(bk_push && of_full))
		else $error("back end pushed into a full result queue");

endmodule
